// File: rtl/core/bse_pkg.sv
// Shared definitions for the bitmap set engine: operation codes and the
// per-word result record. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bse_pkg;

  typedef logic [3:0] act_t;

  localparam act_t ACT_SET       = 4'd0;
  localparam act_t ACT_SET_RANGE = 4'd1;
  localparam act_t ACT_CLR       = 4'd2;
  localparam act_t ACT_CLR_RANGE = 4'd3;
  localparam act_t ACT_TEST      = 4'd4;
  localparam act_t ACT_ALL       = 4'd5;
  localparam act_t ACT_ANY       = 4'd6;
  localparam act_t ACT_NEXT      = 4'd7;
  localparam act_t ACT_LAST      = 4'd8;
  localparam act_t ACT_COUNT     = 4'd9;
  localparam act_t ACT_RUN       = 4'd10;
  localparam act_t ACT_EMPTY     = 4'd11;
  localparam act_t ACT_FILL      = 4'd12;
  localparam act_t ACT_CUT       = 4'd13;

  localparam int unsigned WORD_BITS = 32;

  typedef struct packed {
    logic       changed;
    logic       hit_any;
    logic       all_ok;
    logic [4:0] first_bit;
    logic [4:0] last_bit;
    logic [5:0] ones;
    logic [5:0] run_len;
  } word_res_t;

endpackage
`default_nettype wire

// File: rtl/core/bse_req_if.sv
// Request channel of the bitmap set engine: valid/ready plus request payload.
// Depends on bse_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface bse_req_if;
  logic              valid;
  logic              ready;
  bse_pkg::act_t     action;
  logic [8:0]        position;
  logic [9:0]        span;

  modport source (output valid, action, position, span, input ready);
  modport sink   (input valid, action, position, span, output ready);
endinterface
`default_nettype wire

// File: rtl/core/bse_rsp_if.sv
// Result channel of the bitmap set engine: valid/ready plus result payload.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface bse_rsp_if;
  logic       valid;
  logic       ready;
  logic       flag;
  logic [8:0] found_index;
  logic       none_found;
  logic [9:0] bit_count;
  logic       out_of_range;

  modport source (output valid, flag, found_index, none_found, bit_count, out_of_range,
                  input ready);
  modport sink   (input valid, flag, found_index, none_found, bit_count, out_of_range,
                  output ready);
endinterface
`default_nettype wire

// File: rtl/core/bitmap_set_engine_core.sv
// Bitmap set engine top level: word store, sequencer and result register.
// Depends on bse_pkg, bse_req_if, bse_rsp_if and bse_word_alu.
//
// Usage: requests arrive on in_req (valid/ready); each carries action,
// position and span. Every request yields exactly one result on out_rsp
// (valid/ready) with flag, found_index, none_found, bit_count, out_of_range.
// The set is STORE_WORDS words of 32 bits in one memory with one write and
// one registered read port. Every request walks all words through the
// shared word unit, one word per cycle, and in_req.ready is high only
// while no request is in progress.
// After rst_n is released a clearing pass writes zero into every word;
// no request is taken during that pass.
// When the receiver stalls, the finished result is held in the output
// register; the next request is accepted meanwhile, and its own result
// waits until the held one is taken.
`timescale 1ns / 1ps
`default_nettype none
module bitmap_set_engine_core #(
  parameter int unsigned STORE_WORDS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bse_req_if.sink    in_req,
  bse_rsp_if.source  out_rsp
);

  localparam int unsigned CAP   = STORE_WORDS * 32;
  localparam int unsigned CAPW  = $clog2(CAP + 1);
  localparam int unsigned IW    = (CAPW > 10) ? CAPW : 10;
  localparam int unsigned EW    = IW + 1;
  localparam int unsigned WW    = IW - 5;
  localparam int unsigned AW    = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int unsigned CW    = $clog2(STORE_WORDS + 1);
  localparam logic [IW-1:0] CAP_I  = IW'(CAP);
  localparam logic [CW-1:0] LAST_W = CW'(STORE_WORDS);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [31:0] mem [STORE_WORDS];
  logic [31:0] rd_data_r;

  logic [1:0]       state_r, state_nxt;
  logic [CW-1:0]    iss_r, iss_nxt;
  logic             proc_valid_r, proc_valid_nxt;
  logic [AW-1:0]    proc_idx_r, proc_idx_nxt;
  bse_pkg::act_t    act_r, act_nxt;
  logic [IW-1:0]    lo_r, lo_nxt, hi_r, hi_nxt;
  logic             oor_r, oor_nxt;
  logic             chg_r, chg_nxt, any_r, any_nxt, all_r, all_nxt;
  logic             fnd_r, fnd_nxt, alive_r, alive_nxt;
  logic [8:0]       found_r, found_nxt;
  logic [9:0]       cnt_r, cnt_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             flag_r, flag_nxt, none_r, none_nxt, oor_out_r, oor_out_nxt;
  logic [8:0]       fidx_r, fidx_nxt;
  logic [9:0]       bcnt_r, bcnt_nxt;

  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [31:0]      wr_data;
  logic [AW-1:0]    rd_addr;

  logic [WW-1:0]    w_ext, lo_w, hi_w;
  logic [4:0]       lo_b, hi_b;
  logic [31:0]      ge_mask, lt_mask;
  logic             set_en, clr_en;
  logic [31:0]      new_word;
  bse_pkg::word_res_t res;

  logic [IW-1:0]    pos_i, endc_i;
  logic [EW-1:0]    end_i;
  logic             pos_oor, rng_oor;
  logic [10:0]      cnt_sum;
  logic [5:0]       add_amt;
  logic             take_req;

  assign in_req.ready  = (state_r == ST_IDLE);
  assign take_req      = in_req.valid && (state_r == ST_IDLE);

  assign w_ext   = WW'(proc_idx_r);
  assign lo_w    = lo_r[IW-1:5];
  assign lo_b    = lo_r[4:0];
  assign hi_w    = hi_r[IW-1:5];
  assign hi_b    = hi_r[4:0];

  always_comb begin
    priority if (w_ext > lo_w) begin
      ge_mask = '1;
    end else if (w_ext == lo_w) begin
      ge_mask = 32'hFFFF_FFFF << lo_b;
    end else begin
      ge_mask = '0;
    end
    priority if (w_ext < hi_w) begin
      lt_mask = '1;
    end else if (w_ext == hi_w) begin
      lt_mask = ~(32'hFFFF_FFFF << hi_b);
    end else begin
      lt_mask = '0;
    end
  end

  assign set_en = (act_r == bse_pkg::ACT_SET) || (act_r == bse_pkg::ACT_SET_RANGE) ||
                  (act_r == bse_pkg::ACT_FILL);
  assign clr_en = (act_r == bse_pkg::ACT_CLR) || (act_r == bse_pkg::ACT_CLR_RANGE) ||
                  (act_r == bse_pkg::ACT_CUT);

  bse_word_alu u_alu (
    .word_data  (rd_data_r),
    .range_mask (ge_mask & lt_mask),
    .start_mask (ge_mask),
    .set_en     (set_en),
    .clr_en     (clr_en),
    .new_word   (new_word),
    .res        (res)
  );

  assign pos_i   = IW'(in_req.position);
  assign end_i   = EW'(in_req.position) + EW'(in_req.span);
  assign rng_oor = (end_i > {1'b0, CAP_I});
  assign endc_i  = rng_oor ? CAP_I : end_i[IW-1:0];
  assign pos_oor = (pos_i >= CAP_I);

  always_comb begin
    if (act_r == bse_pkg::ACT_RUN) begin
      add_amt = (w_ext == lo_w) ? (res.run_len - {1'b0, lo_b}) : res.run_len;
    end else begin
      add_amt = res.ones;
    end
  end
  assign cnt_sum = {1'b0, cnt_r} + 11'(add_amt);

  assign rd_addr = iss_r[AW-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = proc_idx_r;
    wr_data = new_word;
    if (state_r == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = iss_r[AW-1:0];
      wr_data = '0;
    end else if (proc_valid_r) begin
      wr_en   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt      = state_r;
    iss_nxt        = iss_r;
    proc_valid_nxt = 1'b0;
    proc_idx_nxt   = proc_idx_r;
    act_nxt        = act_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    oor_nxt        = oor_r;
    chg_nxt        = chg_r;
    any_nxt        = any_r;
    all_nxt        = all_r;
    fnd_nxt        = fnd_r;
    alive_nxt      = alive_r;
    found_nxt      = found_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    flag_nxt       = flag_r;
    none_nxt       = none_r;
    oor_out_nxt    = oor_out_r;
    fidx_nxt       = fidx_r;
    bcnt_nxt       = bcnt_r;

    unique case (state_r)
      ST_CLEAR: begin
        iss_nxt = iss_r + 1'b1;
        if (iss_r == LAST_W - 1'b1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (take_req) begin
          state_nxt = ST_RUN;
          iss_nxt   = '0;
          act_nxt   = in_req.action;
          chg_nxt   = 1'b0;
          any_nxt   = 1'b0;
          all_nxt   = 1'b1;
          fnd_nxt   = 1'b0;
          alive_nxt = 1'b1;
          found_nxt = '0;
          cnt_nxt   = '0;
          lo_nxt    = pos_i;
          hi_nxt    = CAP_I;
          oor_nxt   = pos_oor;
          unique case (in_req.action)
            bse_pkg::ACT_SET, bse_pkg::ACT_CLR, bse_pkg::ACT_TEST: begin
              hi_nxt = pos_i + 1'b1;
            end
            bse_pkg::ACT_SET_RANGE, bse_pkg::ACT_CLR_RANGE,
            bse_pkg::ACT_ALL, bse_pkg::ACT_ANY: begin
              hi_nxt  = endc_i;
              oor_nxt = rng_oor;
            end
            bse_pkg::ACT_NEXT, bse_pkg::ACT_RUN, bse_pkg::ACT_CUT: begin
              hi_nxt = CAP_I;
            end
            bse_pkg::ACT_LAST, bse_pkg::ACT_COUNT, bse_pkg::ACT_EMPTY: begin
              lo_nxt  = '0;
              oor_nxt = 1'b0;
            end
            bse_pkg::ACT_FILL: begin
              lo_nxt = '0;
              hi_nxt = pos_oor ? CAP_I : (pos_i + 1'b1);
            end
            default: begin
              lo_nxt  = '0;
              hi_nxt  = '0;
              oor_nxt = 1'b0;
            end
          endcase
        end
      end
      ST_RUN: begin
        if (iss_r != LAST_W) begin
          iss_nxt        = iss_r + 1'b1;
          proc_valid_nxt = 1'b1;
          proc_idx_nxt   = iss_r[AW-1:0];
        end else if (!proc_valid_r) begin
          state_nxt = ST_DONE;
        end
        if (proc_valid_r) begin
          chg_nxt = chg_r | res.changed;
          any_nxt = any_r | res.hit_any;
          all_nxt = all_r & res.all_ok;
          if (act_r == bse_pkg::ACT_LAST) begin
            if (res.hit_any) begin
              fnd_nxt   = 1'b1;
              found_nxt = 9'({w_ext, res.last_bit});
            end
          end else if (!fnd_r && res.hit_any) begin
            fnd_nxt   = 1'b1;
            found_nxt = 9'({w_ext, res.first_bit});
          end
          if (act_r == bse_pkg::ACT_RUN) begin
            if (alive_r && (w_ext >= lo_w)) begin
              cnt_nxt = cnt_sum[10] ? 10'h3FF : cnt_sum[9:0];
              if (res.run_len != 6'd32) begin
                alive_nxt = 1'b0;
              end
            end
          end else begin
            cnt_nxt = cnt_sum[10] ? 10'h3FF : cnt_sum[9:0];
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_rsp.ready) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          oor_out_nxt   = oor_r;
          flag_nxt      = 1'b0;
          fidx_nxt      = '0;
          none_nxt      = 1'b0;
          bcnt_nxt      = '0;
          unique case (act_r)
            bse_pkg::ACT_SET, bse_pkg::ACT_SET_RANGE, bse_pkg::ACT_FILL,
            bse_pkg::ACT_CLR, bse_pkg::ACT_CLR_RANGE, bse_pkg::ACT_CUT: begin
              flag_nxt = chg_r;
            end
            bse_pkg::ACT_TEST, bse_pkg::ACT_ANY: begin
              flag_nxt = any_r;
            end
            bse_pkg::ACT_ALL: begin
              flag_nxt = all_r & ~oor_r;
            end
            bse_pkg::ACT_EMPTY: begin
              flag_nxt = ~any_r;
            end
            bse_pkg::ACT_NEXT, bse_pkg::ACT_LAST: begin
              fidx_nxt = found_r;
              none_nxt = ~fnd_r;
            end
            bse_pkg::ACT_COUNT, bse_pkg::ACT_RUN: begin
              bcnt_nxt = cnt_r;
            end
            default: begin
              flag_nxt = 1'b0;
            end
          endcase
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      iss_r        <= '0;
      proc_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      iss_r        <= iss_nxt;
      proc_valid_r <= proc_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    proc_idx_r <= proc_idx_nxt;
    act_r      <= act_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    oor_r      <= oor_nxt;
    chg_r      <= chg_nxt;
    any_r      <= any_nxt;
    all_r      <= all_nxt;
    fnd_r      <= fnd_nxt;
    alive_r    <= alive_nxt;
    found_r    <= found_nxt;
    cnt_r      <= cnt_nxt;
    flag_r     <= flag_nxt;
    none_r     <= none_nxt;
    oor_out_r  <= oor_out_nxt;
    fidx_r     <= fidx_nxt;
    bcnt_r     <= bcnt_nxt;
  end

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.flag         = flag_r;
  assign out_rsp.found_index  = fidx_r;
  assign out_rsp.none_found   = none_r;
  assign out_rsp.bit_count    = bcnt_r;
  assign out_rsp.out_of_range = oor_out_r;

endmodule
`default_nettype wire

// File: rtl/core/bse_word_alu.sv
// Shared per-word unit: masked set/clear, test, bit search, popcount and
// run length on one 32-bit store word. Depends on bse_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bse_word_alu (
  input  wire logic [31:0]       word_data,
  input  wire logic [31:0]       range_mask,
  input  wire logic [31:0]       start_mask,
  input  wire logic              set_en,
  input  wire logic              clr_en,
  output logic [31:0]            new_word,
  output bse_pkg::word_res_t     res
);

  logic [31:0] hit;
  logic [31:0] run_src;

  assign hit     = word_data & range_mask;
  assign run_src = word_data | ~start_mask;

  always_comb begin
    priority if (set_en) begin
      new_word = word_data | range_mask;
    end else if (clr_en) begin
      new_word = word_data & ~range_mask;
    end else begin
      new_word = word_data;
    end
  end

  always_comb begin
    res           = '0;
    res.changed   = set_en ? |(range_mask & ~word_data) : (clr_en ? |hit : 1'b0);
    res.hit_any   = |hit;
    res.all_ok    = (hit == range_mask);
    for (int i = 31; i >= 0; i--) begin
      if (hit[i]) begin
        res.first_bit = 5'(i);
      end
    end
    for (int i = 0; i < 32; i++) begin
      if (hit[i]) begin
        res.last_bit = 5'(i);
      end
    end
    for (int i = 0; i < 32; i++) begin
      res.ones = res.ones + 6'(hit[i]);
    end
    res.run_len = 6'd32;
    for (int i = 31; i >= 0; i--) begin
      if (!run_src[i]) begin
        res.run_len = 6'(i);
      end
    end
  end

endmodule
`default_nettype wire

// File: tb/bse_tb_if.sv
// Testbench package: the result record that the checker compares field by field.
// No dependencies.
`timescale 1ns / 1ps
package bse_tb_pkg;

  typedef struct packed {
    logic       flag;
    logic [8:0] found_index;
    logic       none_found;
    logic [9:0] bit_count;
    logic       out_of_range;
  } bse_result_t;
endpackage

// File: tb/tb_top.sv
// Self-checking testbench for bitmap_set_engine_core: drives bit set requests,
// predicts every result with a behavioral bit set and checks them in order.
// Depends on bse_pkg, bse_req_if, bse_rsp_if and bse_tb_pkg.
`timescale 1ns / 1ps
module tb_top;

  localparam int CAP = 512;
  localparam int CYCLE_LIMIT = 400000;
  localparam bse_pkg::act_t ACT_UNUSED_LO = 4'd14;
  localparam bse_pkg::act_t ACT_UNUSED_HI = 4'd15;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bse_req_if in_req();
  bse_rsp_if out_rsp();

  bitmap_set_engine_core dut (
    .clk(clk), .rst_n(rst_n), .in_req(in_req.sink), .out_rsp(out_rsp.source)
  );

  logic [CAP-1:0] model_bits;
  bse_tb_pkg::bse_result_t pending_results[$];
  int send_idle_pct, recv_idle_pct;
  int hold_off_cycles;
  int errors, sent_cnt, checked_cnt;
  int cycle_cnt;

  initial begin
    in_req.valid = 1'b0;
    in_req.action = bse_pkg::ACT_SET;
    in_req.position = '0;
    in_req.span = '0;
    out_rsp.ready = 1'b0;
  end

  function automatic bse_tb_pkg::bse_result_t predict_op(bse_pkg::act_t act, int pos,
                                                         int span);
    bse_tb_pkg::bse_result_t r;
    int fin, clip, n;
    logic [CAP-1:0] prev;
    r = '0;
    fin = pos + span;
    clip = (fin > CAP) ? CAP : fin;
    prev = model_bits;
    case (act)
      bse_pkg::ACT_SET, bse_pkg::ACT_CLR: begin
        if (pos >= CAP) r.out_of_range = 1'b1;
        else model_bits[pos] = (act == bse_pkg::ACT_SET);
      end
      bse_pkg::ACT_SET_RANGE, bse_pkg::ACT_CLR_RANGE: begin
        r.out_of_range = fin > CAP;
        for (int i = pos; i < clip; i++) model_bits[i] = (act == bse_pkg::ACT_SET_RANGE);
      end
      bse_pkg::ACT_TEST: begin
        r.out_of_range = pos >= CAP;
        r.flag = (pos < CAP) ? model_bits[pos] : 1'b0;
      end
      bse_pkg::ACT_ALL: begin
        r.out_of_range = fin > CAP;
        r.flag = !r.out_of_range;
        for (int i = pos; i < clip; i++) if (!model_bits[i]) r.flag = 1'b0;
      end
      bse_pkg::ACT_ANY: begin
        r.out_of_range = fin > CAP;
        for (int i = pos; i < clip; i++) if (model_bits[i]) r.flag = 1'b1;
      end
      bse_pkg::ACT_NEXT: begin
        r.out_of_range = pos >= CAP;
        r.none_found = 1'b1;
        for (int i = pos; i < CAP; i++)
          if (model_bits[i] && r.none_found) begin
            r.found_index = 9'(i);
            r.none_found = 1'b0;
          end
      end
      bse_pkg::ACT_LAST: begin
        r.none_found = 1'b1;
        for (int i = CAP - 1; i >= 0; i--)
          if (model_bits[i] && r.none_found) begin
            r.found_index = 9'(i);
            r.none_found = 1'b0;
          end
      end
      bse_pkg::ACT_COUNT: begin
        n = $countones(model_bits);
        r.bit_count = (n > 1023) ? 10'd1023 : 10'(n);
      end
      bse_pkg::ACT_RUN: begin
        r.out_of_range = pos >= CAP;
        n = 0;
        for (int i = pos; i < CAP && model_bits[i]; i++) n++;
        r.bit_count = (n > 1023) ? 10'd1023 : 10'(n);
      end
      bse_pkg::ACT_EMPTY: r.flag = (model_bits == '0);
      bse_pkg::ACT_FILL: begin
        r.out_of_range = pos >= CAP;
        for (int i = 0; i < ((pos >= CAP) ? CAP : pos + 1); i++) model_bits[i] = 1'b1;
      end
      bse_pkg::ACT_CUT: begin
        if (pos >= CAP) r.out_of_range = 1'b1;
        else for (int i = pos; i < CAP; i++) model_bits[i] = 1'b0;
      end
      default: ;
    endcase
    if (act inside {bse_pkg::ACT_SET, bse_pkg::ACT_SET_RANGE, bse_pkg::ACT_FILL})
      r.flag = |(model_bits & ~prev);
    else if (act inside {bse_pkg::ACT_CLR, bse_pkg::ACT_CLR_RANGE, bse_pkg::ACT_CUT})
      r.flag = |(prev & ~model_bits);
    return r;
  endfunction

  task automatic send_request(bse_pkg::act_t act, int pos, int span);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_req.valid <= 1'b0;
      @(negedge clk);
    end
    in_req.valid <= 1'b1;
    in_req.action <= act;
    in_req.position <= pos[8:0];
    in_req.span <= span[9:0];
    do @(posedge clk); while (!in_req.ready);
    pending_results.push_back(predict_op(act, pos, span));
    sent_cnt++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_req.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (25) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_rsp.ready <= 1'b0;
    end else begin
      out_rsp.ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    bse_tb_pkg::bse_result_t got, want;
    if (rst_n && out_rsp.valid && out_rsp.ready) begin
      got = '{out_rsp.flag, out_rsp.found_index, out_rsp.none_found,
              out_rsp.bit_count, out_rsp.out_of_range};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        checked_cnt++;
        if (got.flag != want.flag || got.found_index != want.found_index ||
            got.none_found != want.none_found || got.bit_count != want.bit_count ||
            got.out_of_range != want.out_of_range) begin
          $display("%0t: mismatch, expected flag=%b idx=%0d none=%b cnt=%0d oor=%b",
                   $time, want.flag, want.found_index, want.none_found,
                   want.bit_count, want.out_of_range);
          $display("%0t:           actual   flag=%b idx=%0d none=%b cnt=%0d oor=%b",
                   $time, got.flag, got.found_index, got.none_found,
                   got.bit_count, got.out_of_range);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic test_directed();
    send_request(bse_pkg::ACT_EMPTY, 0, 0);
    send_request(bse_pkg::ACT_LAST, 0, 0);
    send_request(bse_pkg::ACT_NEXT, 0, 0);
    send_request(bse_pkg::ACT_SET, 0, 0);
    send_request(bse_pkg::ACT_SET, 511, 0);
    send_request(bse_pkg::ACT_SET, 511, 0);
    send_request(bse_pkg::ACT_TEST, 511, 0);
    send_request(bse_pkg::ACT_SET_RANGE, 500, 512);
    send_request(bse_pkg::ACT_ALL, 500, 12);
    send_request(bse_pkg::ACT_ALL, 500, 13);
    send_request(bse_pkg::ACT_ANY, 100, 0);
    send_request(bse_pkg::ACT_ALL, 100, 0);
    send_request(bse_pkg::ACT_RUN, 500, 0);
    send_request(bse_pkg::ACT_CLR, 505, 0);
    send_request(bse_pkg::ACT_CLR, 505, 0);
    send_request(bse_pkg::ACT_ANY, 511, 1023);
    send_request(bse_pkg::ACT_CLR_RANGE, 0, 1023);
    send_request(bse_pkg::ACT_FILL, 511, 0);
    send_request(bse_pkg::ACT_COUNT, 0, 0);
    send_request(bse_pkg::ACT_RUN, 0, 0);
    send_request(bse_pkg::ACT_CUT, 1, 0);
    send_request(bse_pkg::ACT_CUT, 0, 0);
    send_request(bse_pkg::ACT_FILL, 37, 0);
    send_request(bse_pkg::ACT_ANY, 37, 1);
    send_request(ACT_UNUSED_LO, 511, 1023);
    send_request(ACT_UNUSED_HI, 0, 0);
  endtask

  task automatic send_random();
    int a, pos, span;
    a = $urandom_range(int'(ACT_UNUSED_HI));
    pos = $urandom_range(511);
    case ($urandom_range(3))
      0: span = $urandom_range(1023);
      1: span = $urandom_range(40);
      default: span = $urandom_range(512 - pos);
    endcase
    if (a >= int'(ACT_UNUSED_LO) && $urandom_range(3) != 0)
      a = $urandom_range(int'(bse_pkg::ACT_CUT));
    send_request(bse_pkg::act_t'(a), pos, span);
  endtask

  task automatic test_random(int count, int s_pct, int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (count) send_random();
    wait_drained();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_cycles = 200;
    repeat (10) send_random();
    wait_drained();
  endtask

  initial begin
    errors = 0;
    sent_cnt = 0;
    checked_cnt = 0;
    cycle_cnt = 0;
    hold_off_cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    model_bits = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    wait_drained();
    test_random(475, 30, 54);
    test_random(475, 54, 30);
    test_backpressure();
    test_random(470, 0, 0);
    $display("Covered all 16 action codes, range clipping and stalls: %0d requests, %0d checked",
             sent_cnt, checked_cnt);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
